>>> rtl/core/prxd_pkg.sv
// ============================================================================
// prxd_pkg
// Shared types and constants for the packet receiver with XOR deframing.
// ============================================================================
package prxd_pkg;

    // Packet store depth and derived widths
    localparam int BUFFER_DEPTH = 64;
    localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int POS_W        = $clog2(BUFFER_DEPTH + 1);

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int EVENT_W  = 3;
    localparam int CFG_IDX_W = 1;

    // Fixed constants
    localparam logic [BYTE_W-1:0] GAP_MAX        = 8'hFF;
    localparam logic [BYTE_W-1:0] START_RESET    = 8'd0;
    localparam logic [BYTE_W-1:0] TIMEOUT_RESET  = 8'd10;
    localparam int                LEN_OVERHEAD   = 4;

    // Result queue depth
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
    localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_BYTE    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_READ    = 2'd3
    } t_opcode;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_STORED   = 3'd2,
        EV_OK       = 3'd3,
        EV_BAD_SUM  = 3'd4,
        EV_TOO_LONG = 3'd5,
        EV_LINE_ERR = 3'd6,
        EV_IGNORED  = 3'd7
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE  = 1'd0,
        REG_GAP_TIMEOUT = 1'd1
    } t_cfg_reg;

    // Control word of a beat leaving the control stage
    typedef struct packed {
        logic   valid;
        t_event event_res;
        logic   packet_ready;
        logic   is_read;
    } t_stage_ctl;

endpackage

>>> rtl/core/prxd_if.sv
// ============================================================================
// prxd_if
// Channel interfaces: input beats, result beats and configuration writes.
// ============================================================================
interface prxd_in_if;
    logic                               valid;
    logic                               ready;
    logic [prxd_pkg::OPCODE_W-1:0]      opcode;
    logic [prxd_pkg::BYTE_W-1:0]        rx_byte;
    logic                               line_error;
    logic [prxd_pkg::INDEX_W-1:0]       read_index;

    modport source (output valid, opcode, rx_byte, line_error, read_index, input ready);
    modport sink   (input valid, opcode, rx_byte, line_error, read_index, output ready);
endinterface

interface prxd_out_if;
    logic                               valid;
    logic                               ready;
    logic [prxd_pkg::EVENT_W-1:0]       event_res;
    logic                               packet_ready;
    logic [prxd_pkg::BYTE_W-1:0]        read_data;

    modport source (output valid, event_res, packet_ready, read_data, input ready);
    modport sink   (input valid, event_res, packet_ready, read_data, output ready);
endinterface

interface prxd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [prxd_pkg::CFG_IDX_W-1:0]     index;
    logic [prxd_pkg::BYTE_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/prxd_ram.sv
// ============================================================================
// prxd_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module prxd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/prxd_ctrl.sv
// ============================================================================
// prxd_ctrl
// Deframing control: configuration, receive state, store access and events.
// ============================================================================
module prxd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prxd_in_if.sink                       i_in,
    prxd_cfg_if.sink                      i_cfg,
    input  logic                          i_credit,
    output logic                          o_wr_en,
    output logic [prxd_pkg::ADDR_W-1:0]   o_wr_addr,
    output logic [prxd_pkg::BYTE_W-1:0]   o_wr_data,
    output logic                          o_rd_en,
    output logic [prxd_pkg::ADDR_W-1:0]   o_rd_addr,
    output prxd_pkg::t_stage_ctl          o_stage
);

    localparam int NEED_W = prxd_pkg::BYTE_W + 2;
    localparam logic [NEED_W-1:0] DEPTH_N = NEED_W'(prxd_pkg::BUFFER_DEPTH);
    localparam logic [NEED_W-1:0] OVER_N  = NEED_W'(prxd_pkg::LEN_OVERHEAD);

    logic [prxd_pkg::BYTE_W-1:0] r_start_byte;
    logic [prxd_pkg::BYTE_W-1:0] r_timeout;
    logic                        r_receiving, n_receiving;
    logic [prxd_pkg::BYTE_W-1:0] r_xor, n_xor;
    logic [prxd_pkg::POS_W-1:0]  r_wpos, n_wpos;
    logic [prxd_pkg::BYTE_W-1:0] r_gap, n_gap;
    logic                        r_ready, n_ready;
    logic [prxd_pkg::BYTE_W-1:0] r_len, n_len;
    prxd_pkg::t_stage_ctl        r_stage, n_stage;

    logic                        fire;
    prxd_pkg::t_opcode           op;
    logic                        recv_eff;
    logic [prxd_pkg::BYTE_W-1:0] xor_new;
    logic [prxd_pkg::BYTE_W-1:0] len_cur;
    logic [NEED_W-1:0]           need;
    logic [NEED_W-1:0]           pos_next;
    logic                        idx_in_range;

    assign i_in.ready  = i_credit;
    assign i_cfg.ready = 1'b1;
    assign fire        = i_in.valid && i_credit;
    assign op          = prxd_pkg::t_opcode'(i_in.opcode);

    // Byte path helpers
    assign recv_eff     = r_receiving && !(r_gap > r_timeout);
    assign xor_new      = r_xor ^ i_in.rx_byte;
    assign len_cur      = (r_wpos == prxd_pkg::POS_W'(1)) ? i_in.rx_byte : r_len;
    assign need         = NEED_W'(len_cur) + OVER_N;
    assign pos_next     = NEED_W'(r_wpos) + NEED_W'(1);
    assign idx_in_range = NEED_W'(i_in.read_index) < DEPTH_N;

    // Next state and store access for one accepted beat
    always_comb begin
        n_receiving = r_receiving;
        n_xor       = r_xor;
        n_wpos      = r_wpos;
        n_gap       = r_gap;
        n_ready     = r_ready;
        n_len       = r_len;
        n_stage     = '{valid: fire, event_res: prxd_pkg::EV_NONE,
                        packet_ready: 1'b0, is_read: 1'b0};
        o_wr_en     = 1'b0;
        o_wr_addr   = r_wpos[prxd_pkg::ADDR_W-1:0];
        o_wr_data   = i_in.rx_byte;
        o_rd_en     = 1'b0;
        o_rd_addr   = prxd_pkg::ADDR_W'(i_in.read_index);
        if (fire) begin
            unique case (op)
                prxd_pkg::OP_BYTE: begin
                    if (i_in.line_error) begin
                        n_receiving       = 1'b0;
                        n_stage.event_res = prxd_pkg::EV_LINE_ERR;
                    end else begin
                        n_gap = '0;
                        if (!recv_eff) begin
                            n_receiving = 1'b0;
                            if (!r_ready && i_in.rx_byte == r_start_byte) begin
                                n_receiving       = 1'b1;
                                n_xor             = i_in.rx_byte;
                                n_wpos            = prxd_pkg::POS_W'(1);
                                o_wr_en           = 1'b1;
                                o_wr_addr         = '0;
                                n_stage.event_res = prxd_pkg::EV_STARTED;
                            end else begin
                                n_stage.event_res = prxd_pkg::EV_IGNORED;
                            end
                        end else if (NEED_W'(r_wpos) >= DEPTH_N) begin
                            n_receiving       = 1'b0;
                            n_stage.event_res = prxd_pkg::EV_TOO_LONG;
                        end else begin
                            o_wr_en = 1'b1;
                            n_wpos  = pos_next[prxd_pkg::POS_W-1:0];
                            n_xor   = xor_new;
                            n_len   = len_cur;
                            if (need >= DEPTH_N) begin
                                n_receiving       = 1'b0;
                                n_stage.event_res = prxd_pkg::EV_TOO_LONG;
                            end else if (pos_next == need) begin
                                n_receiving = 1'b0;
                                if (xor_new == '0) begin
                                    n_ready           = 1'b1;
                                    n_stage.event_res = prxd_pkg::EV_OK;
                                end else begin
                                    n_stage.event_res = prxd_pkg::EV_BAD_SUM;
                                end
                            end else begin
                                n_stage.event_res = prxd_pkg::EV_STORED;
                            end
                        end
                    end
                end
                prxd_pkg::OP_TICK: begin
                    if (r_gap < prxd_pkg::GAP_MAX) begin
                        n_gap = r_gap + prxd_pkg::BYTE_W'(1);
                    end
                end
                prxd_pkg::OP_RELEASE: begin
                    n_ready = 1'b0;
                end
                prxd_pkg::OP_READ: begin
                    o_rd_en         = idx_in_range;
                    n_stage.is_read = idx_in_range;
                end
                default: begin
                end
            endcase
        end
        n_stage.packet_ready = n_ready;
    end

    // Hold configuration, advance receive state and the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= prxd_pkg::START_RESET;
            r_timeout    <= prxd_pkg::TIMEOUT_RESET;
            r_receiving  <= 1'b0;
            r_xor        <= '0;
            r_wpos       <= '0;
            r_gap        <= '0;
            r_ready      <= 1'b0;
            r_len        <= '0;
            r_stage      <= '{valid: 1'b0, event_res: prxd_pkg::EV_NONE,
                              packet_ready: 1'b0, is_read: 1'b0};
        end else begin
            if (i_cfg.valid) begin
                unique case (prxd_pkg::t_cfg_reg'(i_cfg.index))
                    prxd_pkg::REG_START_BYTE:  r_start_byte <= i_cfg.data;
                    prxd_pkg::REG_GAP_TIMEOUT: r_timeout    <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            r_receiving <= n_receiving;
            r_xor       <= n_xor;
            r_wpos      <= n_wpos;
            r_gap       <= n_gap;
            r_ready     <= n_ready;
            r_len       <= n_len;
            r_stage     <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

>>> rtl/core/prxd_obuf.sv
// ============================================================================
// prxd_obuf
// Result queue: joins stage control with RAM read data and buffers beats.
// ============================================================================
module prxd_obuf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prxd_pkg::t_stage_ctl          i_stage,
    input  logic [prxd_pkg::BYTE_W-1:0]   i_rd_data,
    output logic                          o_credit,
    prxd_out_if.source                    o_out
);

    logic [prxd_pkg::EVENT_W-1:0]    r_ev   [prxd_pkg::OBUF_DEPTH];
    logic                            r_rdy  [prxd_pkg::OBUF_DEPTH];
    logic [prxd_pkg::BYTE_W-1:0]     r_data [prxd_pkg::OBUF_DEPTH];
    logic [prxd_pkg::OBUF_PTR_W-1:0] r_wptr, r_rptr;
    logic [prxd_pkg::OBUF_CNT_W-1:0] r_count, n_count;
    logic                            push, pop;

    assign push = i_stage.valid;
    assign pop  = o_out.valid && o_out.ready;

    // Leave room for the beat in the control stage
    assign o_credit = (prxd_pkg::OBUF_CNT_W'(r_count) + prxd_pkg::OBUF_CNT_W'(i_stage.valid))
                      < prxd_pkg::OBUF_CNT_W'(prxd_pkg::OBUF_DEPTH);

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + prxd_pkg::OBUF_CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - prxd_pkg::OBUF_CNT_W'(1);
        end
    end

    // Store pushed beats, zero data for anything but a read
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ev[r_wptr]   <= i_stage.event_res;
            r_rdy[r_wptr]  <= i_stage.packet_ready;
            r_data[r_wptr] <= i_stage.is_read ? i_rd_data : '0;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + prxd_pkg::OBUF_PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + prxd_pkg::OBUF_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_out.valid        = (r_count != '0);
    assign o_out.event_res    = r_ev[r_rptr];
    assign o_out.packet_ready = r_rdy[r_rptr];
    assign o_out.read_data    = r_data[r_rptr];

endmodule

>>> rtl/core/packet_receiver_xor_deframer_top.sv
// ============================================================================
// packet_receiver_xor_deframer_top
// Serial packet receiver with start byte, length, gap timeout and XOR check.
// ============================================================================
//  Channel  Dir  Payload                                   Beat when
//  i_in     in   opcode, rx_byte, line_error, read_index   valid && ready
//  o_out    out  event_res, packet_ready, read_data        valid && ready
//  i_cfg    in   index, data                               valid && ready
//
//  One beat per cycle enters unless the result queue holds it off; the
//  control stage and the packet store's registered read run side by side,
//  so a result passes the stage register before it joins the queue.
//  A four-entry result queue lets input continue while results wait; input
//  stalls once the queued beats plus the one in the control stage reach four.
//  Reset is synchronous, active low; the store needs no clearing; config is always ready.
// ============================================================================
module packet_receiver_xor_deframer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    prxd_in_if.sink      i_in,
    prxd_cfg_if.sink     i_cfg,
    prxd_out_if.source   o_out
);

    logic                          credit;
    logic                          wr_en;
    logic [prxd_pkg::ADDR_W-1:0]   wr_addr;
    logic [prxd_pkg::BYTE_W-1:0]   wr_data;
    logic                          rd_en;
    logic [prxd_pkg::ADDR_W-1:0]   rd_addr;
    logic [prxd_pkg::BYTE_W-1:0]   rd_data;
    prxd_pkg::t_stage_ctl          stage;

    // Receive control
    prxd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_credit  (credit),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_stage   (stage)
    );

    // Packet store
    prxd_ram #(
        .WIDTH (prxd_pkg::BYTE_W),
        .DEPTH (prxd_pkg::BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Result queue
    prxd_obuf u_obuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .i_rd_data (rd_data),
        .o_credit  (credit),
        .o_out     (o_out)
    );

endmodule

>>> sim/packet_receiver_xor_deframer_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// packet_receiver_xor_deframer_top_test
// Self-checking bench for the packet receiver with XOR deframing. A class
// tracks framing state, gap timer, ready flag and the packet store, predicts
// one result per input beat and matches every result beat against it. The
// stimulus is a short directed part, then random packets with random content
// and gaps, mixed with noise, over several register settings and idle modes.
// ============================================================================
module packet_receiver_xor_deframer_top_test;
    import prxd_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_BEATS   = 195;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        t_opcode             opcode;
        logic [BYTE_W-1:0]   rx_byte;
        logic                line_error;
        logic [INDEX_W-1:0]  read_index;
    } t_deframer_beat;

    typedef struct packed {
        t_event              event_res;
        logic                packet_ready;
        logic [BYTE_W-1:0]   read_data;
    } t_deframer_result;

    // Predicts the block's results and matches them in order
    class packet_deframer_checker;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] gap_timeout;
        bit                receiving;
        logic [BYTE_W-1:0] running_xor;
        logic [POS_W-1:0]  write_pos;
        logic [BYTE_W-1:0] gap_timer;
        bit                ready_flag;
        logic [BYTE_W-1:0] packet_store [BUFFER_DEPTH];
        bit                written [BUFFER_DEPTH];
        int                written_count;
        t_deframer_result  pending_results [$];
        int                mismatches;
        int                results_checked;
        int                event_count [8];
        int                op_count [4];

        function new();
            start_byte    = START_RESET;
            gap_timeout   = TIMEOUT_RESET;
            receiving     = 0;
            running_xor   = '0;
            write_pos     = '0;
            gap_timer     = '0;
            ready_flag    = 0;
            written_count = 0;
            mismatches    = 0;
            results_checked = 0;
            foreach (written[i]) written[i] = 0;
            foreach (event_count[i]) event_count[i] = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [BYTE_W-1:0] value);
            if (idx == REG_START_BYTE)
                start_byte = value;
            else
                gap_timeout = value;
        endfunction

        function void store_byte(logic [BYTE_W-1:0] data);
            if (!written[write_pos[ADDR_W-1:0]]) begin
                written[write_pos[ADDR_W-1:0]] = 1;
                written_count++;
            end
            packet_store[write_pos[ADDR_W-1:0]] = data;
            write_pos++;
        endfunction

        // Framing step for one received byte
        function t_event take_byte(logic [BYTE_W-1:0] data, logic err);
            int need;
            if (err) begin
                receiving = 0;
                return EV_LINE_ERR;
            end
            // Drop a partial packet after a long gap; every clean byte clears the timer
            if (gap_timer > gap_timeout)
                receiving = 0;
            gap_timer = '0;
            if (!receiving) begin
                if (!ready_flag && data == start_byte) begin
                    receiving   = 1;
                    running_xor = data;
                    write_pos   = '0;
                    store_byte(data);
                    return EV_STARTED;
                end
                return EV_IGNORED;
            end
            if (write_pos >= BUFFER_DEPTH) begin
                receiving = 0;
                return EV_TOO_LONG;
            end
            store_byte(data);
            running_xor = running_xor ^ data;
            // Plain compare of the full length, no 8-bit wrap
            need = int'(packet_store[1]) + LEN_OVERHEAD;
            if (need >= BUFFER_DEPTH) begin
                receiving = 0;
                return EV_TOO_LONG;
            end
            if (int'(write_pos) == need) begin
                receiving = 0;
                if (running_xor == '0) begin
                    ready_flag = 1;
                    return EV_OK;
                end
                return EV_BAD_SUM;
            end
            return EV_STORED;
        endfunction

        function void note_input(t_deframer_beat beat);
            t_deframer_result exp;
            exp.event_res = EV_NONE;
            exp.read_data = '0;
            case (beat.opcode)
                OP_BYTE: begin
                    exp.event_res = take_byte(beat.rx_byte, beat.line_error);
                end
                OP_TICK: begin
                    if (gap_timer != GAP_MAX)
                        gap_timer++;
                end
                OP_RELEASE: begin
                    ready_flag = 0;
                end
                default: begin
                    exp.read_data = packet_store[beat.read_index];
                end
            endcase
            exp.packet_ready = ready_flag;
            event_count[exp.event_res]++;
            op_count[beat.opcode]++;
            pending_results.push_back(exp);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_deframer_result got);
            t_deframer_result exp;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result ev=%0d rdy=%0d data=%02h",
                    got.event_res, got.packet_ready, got.read_data));
                return;
            end
            exp = pending_results.pop_front();
            results_checked++;
            if (got.event_res !== exp.event_res)
                report_mismatch($sformatf("result %0d event_res got %0d want %0d",
                    results_checked, got.event_res, exp.event_res));
            if (got.packet_ready !== exp.packet_ready)
                report_mismatch($sformatf("result %0d packet_ready got %0d want %0d",
                    results_checked, got.packet_ready, exp.packet_ready));
            if (got.read_data !== exp.read_data)
                report_mismatch($sformatf("result %0d read_data got %02h want %02h",
                    results_checked, got.read_data, exp.read_data));
        endtask

        function int pending();
            return pending_results.size();
        endfunction

        // Pick a store entry that has been written (random when none is)
        function logic [INDEX_W-1:0] any_written_index();
            logic [INDEX_W-1:0] idx;
            for (int tries = 0; tries < 64; tries++) begin
                idx = INDEX_W'($urandom_range(0, BUFFER_DEPTH - 1));
                if (written[idx])
                    return idx;
            end
            for (int i = 0; i < BUFFER_DEPTH; i++)
                if (written[i])
                    return INDEX_W'(i);
            return INDEX_W'($urandom_range(0, BUFFER_DEPTH - 1));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    prxd_in_if  in_if ();
    prxd_cfg_if cfg_if ();
    prxd_out_if out_if ();

    packet_receiver_xor_deframer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    packet_deframer_checker deframer_chk = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int beats_sent     = 0;

    t_deframer_result out_seen;
    bit               out_hit = 1'b0;

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Sample the result handshake between edges, where it is stable
    always @(negedge i_clk) begin : result_sample
        out_hit               = i_rst_n && out_if.valid && out_if.ready;
        out_seen.event_res    = t_event'(out_if.event_res);
        out_seen.packet_ready = out_if.packet_ready;
        out_seen.read_data    = out_if.read_data;
    end

    // Result side: random stall, check every accepted beat
    always @(posedge i_clk) begin : result_sink
        if (out_hit)
            deframer_chk.check_result(out_seen);
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Drive one input beat, idling first at random; valid stays high afterwards
    task automatic send_item(t_deframer_beat beat);
        bit taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.opcode     <= beat.opcode;
        in_if.rx_byte    <= beat.rx_byte;
        in_if.line_error <= beat.line_error;
        in_if.read_index <= beat.read_index;
        // Ready comes from registers, so its value between edges holds at the edge
        do begin
            @(negedge i_clk);
            taken = in_if.ready;
            @(posedge i_clk);
        end while (!taken);
        deframer_chk.note_input(beat);
        beats_sent++;
    endtask

    task automatic send_op(t_opcode op, logic [BYTE_W-1:0] data, logic err,
                           logic [INDEX_W-1:0] idx);
        t_deframer_beat beat;
        beat.opcode     = op;
        beat.rx_byte    = data;
        beat.line_error = err;
        beat.read_index = idx;
        send_item(beat);
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] data, logic err);
        send_op(OP_BYTE, data, err, deframer_chk.any_written_index());
    endtask

    task automatic send_tick();
        send_op(OP_TICK, 8'($urandom), 1'($urandom), deframer_chk.any_written_index());
    endtask

    task automatic send_release();
        send_op(OP_RELEASE, 8'($urandom), 1'($urandom), deframer_chk.any_written_index());
    endtask

    // Read a written entry only
    task automatic send_read();
        if (deframer_chk.written_count > 0)
            send_op(OP_READ, 8'($urandom), 1'($urandom), deframer_chk.any_written_index());
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(logic [BYTE_W-1:0] start_val, logic [BYTE_W-1:0] timeout_val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= REG_START_BYTE;
        cfg_if.data  <= start_val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        deframer_chk.set_register(REG_START_BYTE, start_val);
        cfg_if.index <= REG_GAP_TIMEOUT;
        cfg_if.data  <= timeout_val;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        deframer_chk.set_register(REG_GAP_TIMEOUT, timeout_val);
        cfg_if.valid <= 1'b0;
    endtask

    // Drop valid and hold until every expected result has come back
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (deframer_chk.pending() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Ticks between bytes: mostly in timeout, sometimes one past, 300 for long_gap
    task automatic inter_byte_gap(bit long_gap);
        int lim;
        if (long_gap) begin
            repeat (300) send_tick();
        end else if ($urandom_range(0, 99) < 10) begin
            lim = (deframer_chk.gap_timeout < 4) ? int'(deframer_chk.gap_timeout) : 4;
            if (lim > 0 && $urandom_range(0, 99) < 80)
                repeat ($urandom_range(1, lim)) send_tick();
            else if (deframer_chk.gap_timeout < 8)
                repeat (int'(deframer_chk.gap_timeout) + 1) send_tick();
        end
    endtask

    // One random sequence: mostly a well-formed packet, sometimes noise
    task automatic send_random_sequence(bit long_gap);
        int                r;
        int                len;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] b;
        bit                bad;
        // Release a waiting packet most of the time so new packets can start
        if (deframer_chk.ready_flag && $urandom_range(0, 99) < 85) begin
            repeat ($urandom_range(0, 3)) send_read();
            send_release();
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0:       send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                1:       send_tick();
                2:       send_release();
                default: send_read();
            endcase
            return;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(0, 6);
        else if (r < 90)
            len = $urandom_range(7, BUFFER_DEPTH - LEN_OVERHEAD - 1);
        else
            len = $urandom_range(BUFFER_DEPTH - LEN_OVERHEAD, 255);
        bad = ($urandom_range(0, 99) < 15);
        acc = deframer_chk.start_byte;
        send_byte(acc, 1'b0);
        inter_byte_gap(1'b0);
        send_byte(8'(len), $urandom_range(0, 99) < 2);
        acc = acc ^ 8'(len);
        // Oversized length: up to two trailing bytes that should normally be ignored
        if (len + LEN_OVERHEAD >= BUFFER_DEPTH) begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
            return;
        end
        inter_byte_gap(long_gap);
        for (int i = 2; i < len + LEN_OVERHEAD; i++) begin
            if (i == len + LEN_OVERHEAD - 1)
                b = bad ? (acc ^ (8'd1 << $urandom_range(0, 7))) : acc;
            else
                b = 8'($urandom);
            send_byte(b, $urandom_range(0, 99) < 2);
            acc = acc ^ b;
            if ($urandom_range(0, 99) < 5)
                send_read();
            if (i < len + LEN_OVERHEAD - 1)
                inter_byte_gap(1'b0);
        end
    endtask

    // Stimulus
    initial begin : stimulus
        logic [BYTE_W-1:0] start_val;
        logic [BYTE_W-1:0] timeout_val;
        int                phase_start;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.opcode     <= OP_BYTE;
        in_if.rx_byte    <= '0;
        in_if.line_error <= 1'b0;
        in_if.read_index <= '0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= REG_START_BYTE;
        cfg_if.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: framing cases with start byte A5 and a timeout of 3 ticks
        set_config(8'hA5, 8'd3);
        send_byte(8'h3C, 1'b0);           // idle non-start byte
        send_byte(8'hA5, 1'b1);           // line error while idle
        send_byte(8'hA5, 1'b0);           // shortest packet, good sum
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'hA5, 1'b0);           // start byte while a packet waits
        send_read();
        send_read();
        send_release();
        send_byte(8'hA5, 1'b0);           // length FF must not wrap
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b0);           // bad checksum
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hA5, 1'b0);           // line error inside a packet
        send_byte(8'h00, 1'b1);
        send_byte(8'hA5, 1'b0);           // gap past the timeout drops the packet
        send_byte(8'h01, 1'b0);
        repeat (4) send_tick();
        send_byte(8'hA5, 1'b0);
        wait_drained();

        // Random phases over register settings and idle modes
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin start_val = 8'h00; timeout_val = 8'd0;   end
                1: begin start_val = 8'hFF; timeout_val = 8'd255; end
                2: begin start_val = 8'($urandom); timeout_val = 8'($urandom_range(1, 20)); end
                3: begin start_val = 8'($urandom); timeout_val = 8'd254; end
                4: begin start_val = 8'($urandom); timeout_val = 8'($urandom); end
                default: begin start_val = 8'h7E; timeout_val = 8'd3; end
            endcase
            case (phase / 2)
                0:       begin send_idle_pct = 25; recv_stall_pct = 79; end
                1:       begin send_idle_pct = 79; recv_stall_pct = 25; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            set_config(start_val, timeout_val);
            phase_start = beats_sent;
            // Saturating timer: 300 ticks inside a packet at the two top timeouts
            if (phase == 1 || phase == 3)
                send_random_sequence(1'b1);
            while (beats_sent - phase_start < PHASE_BEATS)
                send_random_sequence(1'b0);
            wait_drained();
        end

        // Final drain, bounded
        for (int w = 0; w < DRAIN_LIMIT && deframer_chk.pending() > 0; w++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (deframer_chk.pending() != 0)
            deframer_chk.report_mismatch($sformatf("%0d results never arrived",
                deframer_chk.pending()));

        $display("covered %0d beats: %0d bytes, %0d ticks, %0d releases, %0d reads",
            beats_sent, deframer_chk.op_count[OP_BYTE], deframer_chk.op_count[OP_TICK],
            deframer_chk.op_count[OP_RELEASE], deframer_chk.op_count[OP_READ]);
        $display("packets ok %0d, bad sum %0d, too long %0d, line errors %0d, ignored %0d",
            deframer_chk.event_count[EV_OK], deframer_chk.event_count[EV_BAD_SUM],
            deframer_chk.event_count[EV_TOO_LONG], deframer_chk.event_count[EV_LINE_ERR],
            deframer_chk.event_count[EV_IGNORED]);
        if (deframer_chk.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
